// ===== rtl/wbtr_pkg.sv =====
// ----------------------------------------------------------------------------
// wbtr_pkg
// Shared widths, types and rounding helpers for the wind bias, tilt and
// rotation pipeline.
// ----------------------------------------------------------------------------
package wbtr_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 18;
  localparam int COEF_FRAC = COEF_W - 2;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int QUO_W     = ACC_W - COEF_FRAC;

  localparam int MODE_W    = 3;
  localparam int BIAS_W    = 3 * SAMPLE_W;
  localparam int ROW_W     = 3 * COEF_W;
  localparam int ROT_W     = 2 * COEF_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = ROW_W;
  localparam int TDATA_W   = ((3 * SAMPLE_W + 7) / 8) * 8;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BIAS    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ROW0    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_ROW1    = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_ROW2    = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_ROT     = CFG_IDX_W'(5);

  // mode bit positions
  localparam int MODE_TILT  = 0;
  localparam int MODE_ROT   = 1;
  localparam int MODE_IDENT = 2;

  typedef logic signed [SAMPLE_W-1:0] smp_t;
  typedef logic signed [COEF_W-1:0]   coef_t;

  typedef struct packed {
    smp_t u;
    smp_t v;
    smp_t w;
    logic clip;
  } vec_t;

  typedef struct packed {
    logic             tilt_en;
    logic             ident;
    smp_t [2:0]       bias;
    coef_t [2:0][2:0] m;   // m[row][col]
  } tilt_cfg_t;

  typedef struct packed {
    smp_t val;
    logic clip;
  } sat_res_t;

  localparam logic signed [ACC_W-1:0] HALF_ACC =
    {{(ACC_W-COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC-1){1'b0}}};

  // clip a wide signed value to the sample range
  function automatic sat_res_t sat_q(input logic signed [QUO_W-1:0] q);
    sat_res_t r;
    logic     fits;
    fits = (&q[QUO_W-1:SAMPLE_W-1]) | ~(|q[QUO_W-1:SAMPLE_W-1]);
    if (fits) begin
      r.val  = q[SAMPLE_W-1:0];
      r.clip = 1'b0;
    end else begin
      r.val  = {q[QUO_W-1], {(SAMPLE_W-1){~q[QUO_W-1]}}};
      r.clip = 1'b1;
    end
    return r;
  endfunction

  // add half an lsb, floor back to the sample format, then clip
  function automatic sat_res_t round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] t;
    t = acc + HALF_ACC;
    return sat_q(t[ACC_W-1:COEF_FRAC]);
  endfunction

endpackage

// ===== rtl/wbtr_tilt.sv =====
// ----------------------------------------------------------------------------
// wbtr_tilt
// Bias removal and 3x3 tilt matrix, three register stages with a
// per-stage ready chain.
// ----------------------------------------------------------------------------
module wbtr_tilt (
  input  logic               clk,
  input  logic               rst_n,
  input  wbtr_pkg::tilt_cfg_t cfg,
  input  logic               src_valid,
  output logic               src_ready,
  input  wbtr_pkg::vec_t     src_vec,
  output logic               dst_valid,
  input  logic               dst_ready,
  output wbtr_pkg::vec_t     dst_vec
);
  import wbtr_pkg::*;

  logic a_v_r, b_v_r, c_v_r;
  logic a_rdy, b_rdy, c_rdy;
  vec_t a_r, a_nxt;
  vec_t b_r;
  vec_t c_r, c_nxt;
  logic signed [PROD_W-1:0] prod_r [3][3];
  logic signed [PROD_W-1:0] prod_nxt [3][3];
  smp_t     xa [3];
  smp_t     xs [3];
  sat_res_t bs [3];
  sat_res_t ts [3];
  logic signed [ACC_W-1:0] acc [3];

  assign c_rdy     = !c_v_r || dst_ready;
  assign b_rdy     = !b_v_r || c_rdy;
  assign a_rdy     = !a_v_r || b_rdy;
  assign src_ready = a_rdy;

  // stage a: bias subtraction
  assign xs[0] = src_vec.u;
  assign xs[1] = src_vec.v;
  assign xs[2] = src_vec.w;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      bs[i] = sat_q(QUO_W'(xs[i]) - QUO_W'(cfg.bias[i]));
    end
    if (cfg.tilt_en) begin
      a_nxt = '{u: bs[0].val, v: bs[1].val, w: bs[2].val,
                clip: bs[0].clip | bs[1].clip | bs[2].clip};
    end else begin
      a_nxt = src_vec;
    end
  end

  // stage b: nine products
  assign xa[0] = a_r.u;
  assign xa[1] = a_r.v;
  assign xa[2] = a_r.w;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_nxt[i][j] = $signed(cfg.m[i][j]) * xa[j];
      end
    end
  end

  // stage c: row sums, rounding and selection
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = ACC_W'(prod_r[i][0]) + ACC_W'(prod_r[i][1]) + ACC_W'(prod_r[i][2]);
      ts[i]  = round_sat(acc[i]);
    end
    if (cfg.tilt_en && !cfg.ident) begin
      c_nxt = '{u: ts[0].val, v: ts[1].val, w: ts[2].val,
                clip: b_r.clip | ts[0].clip | ts[1].clip | ts[2].clip};
    end else begin
      c_nxt = b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      if (a_rdy) a_v_r <= src_valid;
      if (b_rdy) b_v_r <= a_v_r;
      if (c_rdy) c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy) a_r <= a_nxt;
    if (b_rdy) begin
      b_r    <= a_r;
      prod_r <= prod_nxt;
    end
    if (c_rdy) c_r <= c_nxt;
  end

  assign dst_valid = c_v_r;
  assign dst_vec   = c_r;

endmodule

// ===== rtl/wind_bias_tilt_rotate_core.sv =====
// ----------------------------------------------------------------------------
// wind_bias_tilt_rotate_core
// Wind vector bias removal, tilt matrix and horizontal rotation, fixed point.
// ----------------------------------------------------------------------------
// pipeline: five register stages (a, b, c, d, e) from the input to out_tvalid,
//   the first one captures the input at its transfer
// throughput: one sample per cycle; the two multiply stages each take a new
//   sample every cycle and every stage stalls only when the one after is full
// reset: synchronous active-low rst_n empties the pipeline and restores the
//   identity matrix, zero biases, zero rotation and mode 7
module wind_bias_tilt_rotate_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [wbtr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wbtr_pkg::CFG_DAT_W-1:0]    cfg_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [wbtr_pkg::TDATA_W-1:0]      in_tdata,   // u_in, v_in, w_in
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [wbtr_pkg::TDATA_W-1:0]      out_tdata,  // u_out, v_out, w_out
  output logic                              out_tuser   // saturated
);
  import wbtr_pkg::*;

  logic [MODE_W-1:0] mode_r;
  logic [BIAS_W-1:0] bias_r;
  logic [ROW_W-1:0]  row_r [3];
  logic [ROT_W-1:0]  rot_r;

  tilt_cfg_t tcfg;
  vec_t      in_vec, t_vec;
  logic      t_valid;
  logic      d_v_r, e_v_r, d_rdy, e_rdy;
  vec_t      d_r, e_r, e_nxt;
  coef_t     sn, cs;
  logic signed [PROD_W-1:0] uc_r, vs_r, vc_r, us_r;
  logic signed [ACC_W-1:0]  nu_acc, nv_acc;
  sat_res_t  nu, nv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_W'(7);
      bias_r   <= '0;
      row_r[0] <= ROW_W'(1) << COEF_FRAC;
      row_r[1] <= ROW_W'(1) << (COEF_FRAC + COEF_W);
      row_r[2] <= ROW_W'(1) << (COEF_FRAC + 2 * COEF_W);
      rot_r    <= ROT_W'(1) << (COEF_FRAC + COEF_W);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MODE: mode_r   <= cfg_data[MODE_W-1:0];
        REG_BIAS: bias_r   <= cfg_data[BIAS_W-1:0];
        REG_ROW0: row_r[0] <= cfg_data[ROW_W-1:0];
        REG_ROW1: row_r[1] <= cfg_data[ROW_W-1:0];
        REG_ROW2: row_r[2] <= cfg_data[ROW_W-1:0];
        REG_ROT:  rot_r    <= cfg_data[ROT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    tcfg.tilt_en = mode_r[MODE_TILT];
    tcfg.ident   = mode_r[MODE_IDENT];
    for (int i = 0; i < 3; i++) begin
      tcfg.bias[i] = bias_r[i*SAMPLE_W +: SAMPLE_W];
      for (int j = 0; j < 3; j++) begin
        tcfg.m[i][j] = row_r[i][j*COEF_W +: COEF_W];
      end
    end
  end

  assign in_vec = '{u: in_tdata[0 +: SAMPLE_W],
                    v: in_tdata[SAMPLE_W +: SAMPLE_W],
                    w: in_tdata[2*SAMPLE_W +: SAMPLE_W],
                    clip: 1'b0};

  wbtr_tilt u_tilt (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (tcfg),
    .src_valid (in_tvalid),
    .src_ready (in_tready),
    .src_vec   (in_vec),
    .dst_valid (t_valid),
    .dst_ready (d_rdy),
    .dst_vec   (t_vec)
  );

  assign e_rdy = !e_v_r || out_tready;
  assign d_rdy = !d_v_r || e_rdy;

  assign sn = rot_r[0 +: COEF_W];
  assign cs = rot_r[COEF_W +: COEF_W];

  // stage e: rotation sums, rounding and selection
  always_comb begin
    nu_acc = ACC_W'(uc_r) + ACC_W'(vs_r);
    nv_acc = ACC_W'(vc_r) - ACC_W'(us_r);
    nu     = round_sat(nu_acc);
    nv     = round_sat(nv_acc);
    if (mode_r[MODE_ROT]) begin
      e_nxt = '{u: nu.val, v: nv.val, w: d_r.w, clip: d_r.clip | nu.clip | nv.clip};
    end else begin
      e_nxt = d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
    end else begin
      if (d_rdy) d_v_r <= t_valid;
      if (e_rdy) e_v_r <= d_v_r;
    end
  end

  // stage d: rotation products
  always_ff @(posedge clk) begin
    if (d_rdy) begin
      d_r  <= t_vec;
      uc_r <= t_vec.u * cs;
      vs_r <= t_vec.v * sn;
      vc_r <= t_vec.v * cs;
      us_r <= t_vec.u * sn;
    end
    if (e_rdy) e_r <= e_nxt;
  end

  assign out_tvalid = e_v_r;
  assign out_tdata  = TDATA_W'({e_r.w, e_r.v, e_r.u});
  assign out_tuser  = e_r.clip;

  // back-pressure only reaches the input when the output holds a result
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled while output is free");

  // a result in the rotation stage moves on when the output stage is free
  a_d_to_e: assert property (@(posedge clk) disable iff (!rst_n)
    (d_v_r && e_rdy) |=> out_tvalid)
    else $error("rotation stage result lost");

  // a pending result stays until its transfer
  a_e_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (e_v_r && !out_tready) |=> (e_v_r && $stable(e_r)))
    else $error("output stage changed while stalled");

endmodule
